### rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, skipped while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked every clock, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/slin_pkg.sv
// types and constants of the sensor polynomial linearizer
package slin_pkg;

   localparam int POLY_TERMS      = 8;
   localparam int Q_FRAC          = 28;
   localparam int RAW_W           = 12;
   localparam int TAG_W           = 3;
   localparam int DATA_W          = 32;
   localparam int CSR_INDEX_W     = 4;
   localparam int NORM_OFFSET_Q16 = 24245535;
   localparam int INV_SCALE_Q28   = 484644;

   // normalize arithmetic widths
   localparam int DIFF_W   = 30;
   localparam int INV_W    = 30;
   localparam int NPROD_W  = DIFF_W + INV_W;
   localparam int NSHIFT_W = NPROD_W - 16;

   // horner step widths
   localparam int HPROD_W  = 2 * DATA_W;
   localparam int HTERM_W  = HPROD_W - Q_FRAC;
   localparam int HSUM_W   = HTERM_W + 1;

   typedef logic signed [DATA_W-1:0] coef_type;
   typedef coef_type [POLY_TERMS-1:0] coef_bank_type;

   localparam coef_bank_type COEF_RESET = {
      -32'sd15949, 32'sd263604, -32'sd1717303, 32'sd5613227,
      -32'sd9703258, 32'sd8762071, -32'sd5036045, 32'sd4630075
   };

   // normalized sample handed from front to back
   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic                     sat;
      logic [TAG_W-1:0]         tag;
   } q_item_type;

   // horner pipeline: after the add and clamp
   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] acc;
      logic                     sat;
      logic [TAG_W-1:0]         tag;
   } h_item_type;

   // horner pipeline: after the multiply
   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [HPROD_W-1:0] prod;
      logic                      sat;
      logic [TAG_W-1:0]          tag;
   } m_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### rtl/slin_queue.sv
// small fifo between the front and back parts
module slin_queue #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output slin_pkg::q_status_type status
);
   import slin_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### rtl/slin_front.sv
// front part: accepts samples and normalizes them to q4.28
module slin_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [slin_pkg::RAW_W-1:0]  req_raw_sample,
   input  logic [slin_pkg::TAG_W-1:0]  req_sensor_number,
   input  slin_pkg::q_status_type      q_status,
   output logic                        q_push,
   output slin_pkg::q_item_type        q_data
);
   import slin_pkg::*;

   logic signed [DIFF_W-1:0]   diff;
   logic signed [NPROD_W-1:0]  nprod_in;
   logic signed [NPROD_W-1:0]  nprod_ff;
   logic [TAG_W-1:0]           tag_ff;
   logic                       valid_ff, valid_in;
   logic signed [NPROD_W-1:0]  rounded;
   logic signed [NSHIFT_W-1:0] shifted;
   logic                       accept;
   logic                       in_range;

   assign accept    = req_valid && req_ready;
   assign req_ready = !valid_ff || !q_status.full;
   assign q_push    = valid_ff && !q_status.full;

   assign diff     = $signed({2'b00, req_raw_sample, 16'h0000})
                   - $signed(DIFF_W'(NORM_OFFSET_Q16));
   assign nprod_in = diff * $signed(INV_W'(INV_SCALE_Q28));

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         nprod_ff <= nprod_in;
         tag_ff   <= req_sensor_number;
      end
   end

   // round half up, then floor shift by 16 and clamp to 32 bits
   always_comb begin
      rounded  = nprod_ff + NPROD_W'(1 << 15);
      shifted  = NSHIFT_W'(rounded >>> 16);
      in_range = (shifted[NSHIFT_W-1:DATA_W-1] == '0)
              || (shifted[NSHIFT_W-1:DATA_W-1] == '1);
      q_data.tag = tag_ff;
      q_data.sat = !in_range;
      if (in_range) begin
         q_data.x = DATA_W'(shifted);
      end else if (shifted[NSHIFT_W-1]) begin
         q_data.x = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         q_data.x = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

endmodule

### rtl/slin_back.sv
// back part: unrolled horner pipeline with output register
module slin_back (
   input  logic                        clock,
   input  logic                        reset,
   input  slin_pkg::coef_bank_type     coef,
   input  slin_pkg::q_status_type      q_status,
   input  slin_pkg::q_item_type        q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [slin_pkg::TAG_W-1:0]  rsp_sensor_tag,
   output logic signed [slin_pkg::DATA_W-1:0] rsp_distance,
   output logic                        rsp_saturated
);
   import slin_pkg::*;

   localparam int STEPS = POLY_TERMS - 1;

   h_item_type st_ff   [STEPS+1];
   logic       st_v_ff [STEPS+1];
   m_item_type mu_ff   [STEPS];
   logic       mu_v_ff [STEPS];
   h_item_type st_in   [STEPS+1];
   m_item_type mu_in   [STEPS];
   logic       advance;

   // the whole pipeline holds while a result waits at the output
   assign advance = !st_v_ff[STEPS] || rsp_ready;
   assign q_pop   = advance && !q_status.empty;

   always_comb begin
      st_in[0].x   = q_data.x;
      st_in[0].acc = coef[POLY_TERMS-1];
      st_in[0].sat = q_data.sat;
      st_in[0].tag = q_data.tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff[0] <= 1'b0;
      end else if (advance) begin
         st_v_ff[0] <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= st_in[0];
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic signed [HPROD_W-1:0] rounded;
      logic signed [HTERM_W-1:0] term;
      logic signed [HSUM_W-1:0]  sum;
      logic                      in_range;

      always_comb begin
         mu_in[s].x    = st_ff[s].x;
         mu_in[s].prod = st_ff[s].acc * st_ff[s].x;
         mu_in[s].sat  = st_ff[s].sat;
         mu_in[s].tag  = st_ff[s].tag;
      end

      // round to q28, add the coefficient, clamp to 32 bits
      always_comb begin
         rounded  = mu_ff[s].prod + HPROD_W'(1 << (Q_FRAC - 1));
         term     = HTERM_W'(rounded >>> Q_FRAC);
         sum      = HSUM_W'(term) + HSUM_W'(coef[POLY_TERMS-2-s]);
         in_range = (sum[HSUM_W-1:DATA_W-1] == '0) || (sum[HSUM_W-1:DATA_W-1] == '1);
         st_in[s+1].x   = mu_ff[s].x;
         st_in[s+1].tag = mu_ff[s].tag;
         st_in[s+1].sat = mu_ff[s].sat || !in_range;
         if (in_range) begin
            st_in[s+1].acc = DATA_W'(sum);
         end else if (sum[HSUM_W-1]) begin
            st_in[s+1].acc = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            st_in[s+1].acc = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mu_v_ff[s]   <= 1'b0;
            st_v_ff[s+1] <= 1'b0;
         end else if (advance) begin
            mu_v_ff[s]   <= st_v_ff[s];
            st_v_ff[s+1] <= mu_v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            mu_ff[s]   <= mu_in[s];
            st_ff[s+1] <= st_in[s+1];
         end
      end
   end

   assign rsp_valid      = st_v_ff[STEPS];
   assign rsp_sensor_tag = st_ff[STEPS].tag;
   assign rsp_distance   = st_ff[STEPS].acc;
   assign rsp_saturated  = st_ff[STEPS].sat;

endmodule

### rtl/sensor_poly_linearize_top.sv
// top level of the sensor polynomial linearizer
// usage:
// - req channel: one raw 12-bit sample with its sensor number per item
// - rsp channel: sensor tag, calibrated distance in q4.28, saturated flag
// - csr channel: index 0..7 writes coef_0..coef_7, higher indexes are
//   ignored; always ready, write only while no item is in flight
// - throughput: one item per cycle sustained while rsp_ready stays high; the
//   front multiply, the queue and the seven multiply plus add stages each take one item a cycle
// - path: from req accept to rsp valid with no stall an item passes the
//   front register (loaded at the accept edge), the queue, one
//   horner input register and fourteen multiply and add stages
// - stall: while a result waits on rsp_ready the back pipeline holds;
//   the queue keeps filling and req_ready drops once it is full and the front register holds an item
// - reset: pipeline and queue empty, coefficients back to their defaults
`include "assert_macros.svh"

module sensor_poly_linearize_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [slin_pkg::RAW_W-1:0]          req_raw_sample,
   input  logic [slin_pkg::TAG_W-1:0]          req_sensor_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [slin_pkg::TAG_W-1:0]          rsp_sensor_tag,
   output logic signed [slin_pkg::DATA_W-1:0]  rsp_distance,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slin_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slin_pkg::DATA_W-1:0]         csr_data
);
   import slin_pkg::*;

   coef_bank_type coef_ff, coef_in;
   q_status_type  q_status;
   q_item_type    push_item;
   q_item_type    pop_item;
   logic          q_push;
   logic          q_pop;
   logic          csr_write;
   logic          csr_high_index;

   assign csr_ready      = 1'b1;
   assign csr_write      = csr_valid && csr_ready;
   assign csr_high_index = csr_write && (csr_index >= CSR_INDEX_W'(POLY_TERMS));

   always_comb begin
      coef_in = coef_ff;
      for (int i = 0; i < POLY_TERMS; i++) begin
         if (csr_write && (csr_index == CSR_INDEX_W'(i))) begin
            coef_in[i] = $signed(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   slin_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_sample    (req_raw_sample),
      .req_sensor_number (req_sensor_number),
      .q_status          (q_status),
      .q_push            (q_push),
      .q_data            (push_item)
   );

   slin_queue #(
      .WIDTH ($bits(q_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_item),
      .pop       (q_pop),
      .pop_data  (pop_item),
      .status    (q_status)
   );

   slin_back u_back (
      .clock          (clock),
      .reset          (reset),
      .coef           (coef_ff),
      .q_status       (q_status),
      .q_data         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sensor_tag (rsp_sensor_tag),
      .rsp_distance   (rsp_distance),
      .rsp_saturated  (rsp_saturated)
   );

   `ASSERT_IMPLY(a_queue_not_full_empty, clock, reset, 1'b1, !(q_status.full && q_status.empty))
   `ASSERT_IMPLY(a_push_has_room, clock, reset, q_push, !q_status.full)
   `ASSERT_NEXT(a_high_index_ignored, clock, reset, csr_high_index, $stable(coef_ff))
   `ASSERT_NEXT_ALWAYS(a_reset_clears_output, clock, reset, !rsp_valid)

endmodule

### bench/tb_sensor_poly_linearize_top.sv
`timescale 1ns / 1ps
// testbench of the sensor polynomial linearizer: directed table, random items, predictor
module tb_sensor_poly_linearize_top;
   import slin_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int DIR_ROWS      = 25;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 50;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;
   localparam int COEF_IDX_W    = $clog2(POLY_TERMS);

   localparam logic signed [DATA_W-1:0] CONST_DIST = 32'sd123456789;
   localparam logic signed [DATA_W-1:0] DIST_MAX   = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] DIST_MIN   = 32'sh80000000;

   typedef enum logic [2:0] {
      PRESET_DEFAULT, PRESET_CONST, PRESET_MAX, PRESET_MIN,
      PRESET_ZERO, PRESET_SMALL, PRESET_MIXED, PRESET_JUNK
   } preset_type;

   typedef enum logic {ROW_ITEM, ROW_SETUP} row_kind_type;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [DATA_W-1:0] distance;
      logic                     saturated;
   } reading_type;

   typedef struct packed {
      row_kind_type             kind;
      preset_type               preset;
      logic [RAW_W-1:0]         raw;
      logic [TAG_W-1:0]         tag;
      logic                     typed;
      logic signed [DATA_W-1:0] want_dist;
      logic                     sat;
   } dir_row_type;

   // typed rows use coefficient sets whose result is obvious
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd4095, 3'd7, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd370,  3'd3, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd369,  3'd4, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd2048, 3'd5, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'hAAA,  3'd2, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'h555,  3'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd1,    3'd6, 1'b0, 32'sd0, 1'b0},
      '{ROW_SETUP, PRESET_CONST,   12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      // writes to indexes past the coefficient bank must change nothing
      '{ROW_SETUP, PRESET_JUNK,    12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_CONST,   12'd0,    3'd1, 1'b1, CONST_DIST, 1'b0},
      '{ROW_ITEM,  PRESET_CONST,   12'd4095, 3'd6, 1'b1, CONST_DIST, 1'b0},
      '{ROW_ITEM,  PRESET_CONST,   12'hAAA,  3'd2, 1'b1, CONST_DIST, 1'b0},
      '{ROW_SETUP, PRESET_MAX,     12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_MAX,     12'd4095, 3'd7, 1'b1, DIST_MAX, 1'b1},
      '{ROW_ITEM,  PRESET_MAX,     12'd2048, 3'd0, 1'b1, DIST_MAX, 1'b1},
      '{ROW_SETUP, PRESET_MIN,     12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_MIN,     12'd4095, 3'd3, 1'b1, DIST_MIN, 1'b1},
      '{ROW_ITEM,  PRESET_MIN,     12'd2048, 3'd5, 1'b1, DIST_MIN, 1'b1},
      '{ROW_SETUP, PRESET_ZERO,    12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_ZERO,    12'd0,    3'd0, 1'b1, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_ZERO,    12'd4095, 3'd7, 1'b1, 32'sd0, 1'b0},
      '{ROW_SETUP, PRESET_DEFAULT, 12'd0,    3'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd0,    3'd2, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM,  PRESET_DEFAULT, 12'd4095, 3'd4, 1'b0, 32'sd0, 1'b0}
   };

   preset_type phase_presets [RANDOM_PHASES] = '{
      PRESET_DEFAULT, PRESET_SMALL, PRESET_MIXED, PRESET_MAX, PRESET_SMALL,
      PRESET_MIN, PRESET_MIXED, PRESET_CONST, PRESET_SMALL
   };

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic [RAW_W-1:0]           req_raw_sample    = '0;
   logic [TAG_W-1:0]           req_sensor_number = '0;
   logic                       rsp_ready         = 1'b0;
   logic                       csr_valid         = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index         = '0;
   logic [DATA_W-1:0]          csr_data          = '0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [TAG_W-1:0]           rsp_sensor_tag;
   logic signed [DATA_W-1:0]   rsp_distance;
   logic                       rsp_saturated;
   logic                       csr_ready;

   logic signed [DATA_W-1:0]   coef_shadow [POLY_TERMS];
   reading_type                pending_readings [$];
   int                         mismatches     = 0;
   int                         send_gap_pct   = 0;
   int                         recv_stall_pct = 0;

   sensor_poly_linearize_top dut (.*);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   function automatic longint clamp_s32(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // normalize, then horner from the top coefficient down
   function automatic reading_type linearize_reading(input logic [RAW_W-1:0] raw,
                                                     input logic [TAG_W-1:0] tag);
      longint      raw_wide;
      longint      diff;
      longint      x;
      longint      acc;
      longint      prod;
      logic        sat;
      reading_type res;
      raw_wide = longint'(raw);
      sat      = 1'b0;
      diff     = raw_wide * 65536 - NORM_OFFSET_Q16;
      x        = clamp_s32((diff * INV_SCALE_Q28 + 64'sd32768) >>> 16, sat);
      acc      = longint'(coef_shadow[POLY_TERMS-1]);
      for (int k = POLY_TERMS - 2; k >= 0; k--) begin
         prod = acc * x;
         acc  = clamp_s32(((prod + (64'sd1 <<< (Q_FRAC - 1))) >>> Q_FRAC) + coef_shadow[k],
                          sat);
      end
      res.tag       = tag;
      res.distance  = acc[DATA_W-1:0];
      res.saturated = sat;
      return res;
   endfunction

   task automatic send_item(input logic [RAW_W-1:0] raw, input logic [TAG_W-1:0] tag,
                            input reading_type want);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_raw_sample    <= raw;
      req_sensor_number <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_readings.push_back(want);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < POLY_TERMS) coef_shadow[idx[COEF_IDX_W-1:0]] = value;
   endtask

   // coefficient writes happen only with the pipeline empty
   task automatic load_preset(input preset_type preset);
      logic [DATA_W-1:0] value;
      wait_drained();
      repeat (2) @(posedge clock);
      if (preset == PRESET_JUNK) begin
         for (int i = POLY_TERMS; i < (1 << CSR_INDEX_W); i++) begin
            csr_write(CSR_INDEX_W'(i), $urandom);
         end
      end else begin
         for (int i = 0; i < POLY_TERMS; i++) begin
            case (preset)
               PRESET_DEFAULT: value = COEF_RESET[i];
               PRESET_CONST:   value = (i == 0) ? CONST_DIST : '0;
               PRESET_MAX:     value = DIST_MAX;
               PRESET_MIN:     value = DIST_MIN;
               PRESET_ZERO:    value = '0;
               PRESET_SMALL:   value = $urandom_range(0, 1 << 28) - (1 << 27);
               default: begin
                  case ($urandom_range(0, 4))
                     0:       value = DIST_MAX;
                     1:       value = DIST_MIN;
                     2:       value = '0;
                     3:       value = $urandom;
                     default: value = $urandom_range(0, 1 << 28) - (1 << 27);
                  endcase
               end
            endcase
            csr_write(CSR_INDEX_W'(i), value);
         end
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected item: tag %0d distance %0d saturated %0b",
                        rsp_sensor_tag, rsp_distance, rsp_saturated);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_sensor_tag !== want.tag || rsp_distance !== want.distance ||
                rsp_saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: want tag %0d dist %0d sat %0b, got tag %0d dist %0d sat %0b",
                           want.tag, want.distance, want.saturated,
                           rsp_sensor_tag, rsp_distance, rsp_saturated);
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [RAW_W-1:0] raw;
      logic [TAG_W-1:0] tag;
      reading_type      want;
      for (int i = 0; i < POLY_TERMS; i++) coef_shadow[i] = COEF_RESET[i];
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SETUP) begin
            load_preset(directed_rows[r].preset);
         end else begin
            if (directed_rows[r].typed) begin
               want.tag       = directed_rows[r].tag;
               want.distance  = directed_rows[r].want_dist;
               want.saturated = directed_rows[r].sat;
            end else begin
               want = linearize_reading(directed_rows[r].raw, directed_rows[r].tag);
            end
            send_item(directed_rows[r].raw, directed_rows[r].tag, want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_preset(phase_presets[p]);
         case (p % 4)
            0: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_gap_pct   = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_gap_pct   = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_gap_pct   = 20;
               recv_stall_pct = 20;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off mid-phase until every item in flight is back
            if (n == PHASE_ITEMS / 2) wait_drained();
            case ($urandom_range(0, 9))
               0:       raw = '0;
               1:       raw = '1;
               2:       raw = RAW_W'($urandom_range(360, 380));
               default: raw = RAW_W'($urandom);
            endcase
            tag = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
            send_item(raw, tag, linearize_reading(raw, tag));
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/slin_pkg.sv
rtl/slin_queue.sv
rtl/slin_front.sv
rtl/slin_back.sv
rtl/sensor_poly_linearize_top.sv
bench/tb_sensor_poly_linearize_top.sv
